/* src/sawt_pkg.sv */
package sawt_pkg;

   // field widths
   localparam int TYPE_W = 8;
   localparam int SEQ_W = 32;
   localparam int MASK_W = 64;
   localparam int BIT_W = 6;
   localparam int VERDICT_W = 2;

   // number of newest sequences reported one by one
   localparam int ACK_WINDOW = 64;
   localparam logic [SEQ_W-1:0] WIN_SPAN = SEQ_W'(ACK_WINDOW - 1);

   // sequence gap at or above which the receive mask keeps only the newest bit
   localparam logic [SEQ_W-1:0] GAP_CLEAR = SEQ_W'(MASK_W);

   // verdict codes
   localparam logic [VERDICT_W-1:0] VERDICT_NONE = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_ACKED = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_DROPPED = 2'd2;

   // register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_TYPE_LIMIT = 1'b0;
   localparam logic [TYPE_W-1:0] TYPE_LIMIT_RESET = 8'd16;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic check;
      logic setup;
      logic advance;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic type_ok;
      logic is_last;
   } sts_type;

endpackage

/* src/sawt_if.sv */
interface sawt_req_if;
   logic                            valid;
   logic                            ready;
   logic [sawt_pkg::TYPE_W-1:0]     packet_type;
   logic [sawt_pkg::SEQ_W-1:0]      rx_sequence;
   logic [sawt_pkg::SEQ_W-1:0]      peer_highest_ack;
   logic [sawt_pkg::MASK_W-1:0]     peer_ack_mask;

   modport source (
      output valid, packet_type, rx_sequence, peer_highest_ack, peer_ack_mask,
      input  ready
   );
   modport sink (
      input  valid, packet_type, rx_sequence, peer_highest_ack, peer_ack_mask,
      output ready
   );
endinterface

interface sawt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sawt_pkg::SEQ_W-1:0]      report_sequence;
   logic [sawt_pkg::VERDICT_W-1:0]  verdict;
   logic [sawt_pkg::SEQ_W-1:0]      older_dropped_first;
   logic [sawt_pkg::SEQ_W-1:0]      older_dropped_count;
   logic [sawt_pkg::MASK_W-1:0]     own_ack_mask;
   logic                            last_of_run;

   modport source (
      output valid, report_sequence, verdict, older_dropped_first,
             older_dropped_count, own_ack_mask, last_of_run,
      input  ready
   );
   modport sink (
      input  valid, report_sequence, verdict, older_dropped_first,
             older_dropped_count, own_ack_mask, last_of_run,
      output ready
   );
endinterface

/* src/sawt_ctrl.sv */
module sawt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  sawt_pkg::sts_type sts,
   output sawt_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_SETUP = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.type_ok) begin
               cmd.check = 1'b1;
               state_in = ST_SETUP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.advance = 1'b1;
               if (sts.is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/sawt_dp.sv */
module sawt_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  sawt_pkg::cmd_type                  cmd,
   output sawt_pkg::sts_type                  sts,
   // configuration
   input  logic                               cfg_write,
   input  logic [sawt_pkg::TYPE_W-1:0]        cfg_type_limit,
   output logic [sawt_pkg::TYPE_W-1:0]        type_limit,
   // incoming header
   input  logic [sawt_pkg::TYPE_W-1:0]        packet_type,
   input  logic [sawt_pkg::SEQ_W-1:0]         rx_sequence,
   input  logic [sawt_pkg::SEQ_W-1:0]         peer_highest_ack,
   input  logic [sawt_pkg::MASK_W-1:0]        peer_ack_mask,
   // result fields
   output logic [sawt_pkg::SEQ_W-1:0]         report_sequence,
   output logic [sawt_pkg::VERDICT_W-1:0]     verdict,
   output logic [sawt_pkg::SEQ_W-1:0]         older_dropped_first,
   output logic [sawt_pkg::SEQ_W-1:0]         older_dropped_count,
   output logic [sawt_pkg::MASK_W-1:0]        own_ack_mask,
   output logic                               last_of_run
);

   // persistent state
   logic [sawt_pkg::TYPE_W-1:0]  type_limit_ff, type_limit_in;
   logic [sawt_pkg::SEQ_W-1:0]   highest_ack_seen_ff, highest_ack_seen_in;
   logic [sawt_pkg::SEQ_W-1:0]   last_rx_sequence_ff, last_rx_sequence_in;
   logic [sawt_pkg::MASK_W-1:0]  receive_mask_ff, receive_mask_in;

   // latched header
   logic [sawt_pkg::TYPE_W-1:0]  type_ff, type_in;
   logic [sawt_pkg::SEQ_W-1:0]   rx_ff, rx_in;
   logic [sawt_pkg::SEQ_W-1:0]   peer_ff, peer_in;
   logic [sawt_pkg::MASK_W-1:0]  peer_mask_ff, peer_mask_in;

   // run working registers
   logic [sawt_pkg::SEQ_W-1:0]   start_ff, start_in;
   logic [sawt_pkg::SEQ_W-1:0]   win_lo_ff, win_lo_in;
   logic [sawt_pkg::SEQ_W-1:0]   cur_ff, cur_in;
   logic [sawt_pkg::SEQ_W-1:0]   old_first_ff, old_first_in;
   logic [sawt_pkg::SEQ_W-1:0]   old_count_ff, old_count_in;
   logic                         first_ff, first_in;
   logic                         none_ff, none_in;

   logic [sawt_pkg::SEQ_W-1:0]   gap;
   logic [sawt_pkg::SEQ_W-1:0]   seen;
   logic [sawt_pkg::SEQ_W-1:0]   offset;
   logic [sawt_pkg::BIT_W-1:0]   bit_sel;

   // status to the controller
   assign sts.type_ok = (type_ff != '0) && (type_ff < type_limit_ff);
   assign sts.is_last = (cur_ff == peer_ff);

   always_comb begin
      type_limit_in = type_limit_ff;
      highest_ack_seen_in = highest_ack_seen_ff;
      last_rx_sequence_in = last_rx_sequence_ff;
      receive_mask_in = receive_mask_ff;
      type_in = type_ff;
      rx_in = rx_ff;
      peer_in = peer_ff;
      peer_mask_in = peer_mask_ff;
      start_in = start_ff;
      win_lo_in = win_lo_ff;
      cur_in = cur_ff;
      old_first_in = old_first_ff;
      old_count_in = old_count_ff;
      first_in = first_ff;
      none_in = none_ff;

      gap = rx_ff - last_rx_sequence_ff;
      seen = (highest_ack_seen_ff == '0) ? (peer_ff - 32'd1) : highest_ack_seen_ff;

      // register write
      if (cfg_write) begin
         type_limit_in = cfg_type_limit;
      end

      // capture header
      if (cmd.load) begin
         type_in = packet_type;
         rx_in = rx_sequence;
         peer_in = peer_highest_ack;
         peer_mask_in = peer_ack_mask;
      end

      // receive mask update and run bounds
      if (cmd.check) begin
         if (gap >= sawt_pkg::GAP_CLEAR) begin
            receive_mask_in = {{(sawt_pkg::MASK_W-1){1'b0}}, 1'b1};
         end else begin
            receive_mask_in = (receive_mask_ff << gap[sawt_pkg::BIT_W-1:0])
                              | {{(sawt_pkg::MASK_W-1){1'b0}}, 1'b1};
         end
         start_in = seen + 32'd1;
         win_lo_in = (peer_ff >= sawt_pkg::WIN_SPAN) ? (peer_ff - sawt_pkg::WIN_SPAN) : '0;
         highest_ack_seen_in = peer_ff;
         last_rx_sequence_in = rx_ff;
      end

      // split the run into older drops and in-window part
      if (cmd.setup) begin
         first_in = 1'b1;
         if (start_ff > peer_ff) begin
            none_in = 1'b1;
            cur_in = peer_ff;
            old_first_in = '0;
            old_count_in = '0;
         end else if (start_ff < win_lo_ff) begin
            none_in = 1'b0;
            cur_in = win_lo_ff;
            old_first_in = start_ff;
            old_count_in = win_lo_ff - start_ff;
         end else begin
            none_in = 1'b0;
            cur_in = start_ff;
            old_first_in = '0;
            old_count_in = '0;
         end
      end

      // step to the next sequence
      if (cmd.advance) begin
         cur_in = cur_ff + 32'd1;
         first_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_limit_ff <= sawt_pkg::TYPE_LIMIT_RESET;
         highest_ack_seen_ff <= '0;
         last_rx_sequence_ff <= '0;
         receive_mask_ff <= '0;
      end else begin
         type_limit_ff <= type_limit_in;
         highest_ack_seen_ff <= highest_ack_seen_in;
         last_rx_sequence_ff <= last_rx_sequence_in;
         receive_mask_ff <= receive_mask_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      type_ff <= type_in;
      rx_ff <= rx_in;
      peer_ff <= peer_in;
      peer_mask_ff <= peer_mask_in;
      start_ff <= start_in;
      win_lo_ff <= win_lo_in;
      cur_ff <= cur_in;
      old_first_ff <= old_first_in;
      old_count_ff <= old_count_in;
      first_ff <= first_in;
      none_ff <= none_in;
   end

   // result fields
   assign offset = peer_ff - cur_ff;
   assign bit_sel = offset[sawt_pkg::BIT_W-1:0];

   always_comb begin
      if (none_ff) begin
         verdict = sawt_pkg::VERDICT_NONE;
      end else if (peer_mask_ff[bit_sel]) begin
         verdict = sawt_pkg::VERDICT_ACKED;
      end else begin
         verdict = sawt_pkg::VERDICT_DROPPED;
      end
   end

   assign report_sequence = cur_ff;
   assign older_dropped_first = first_ff ? old_first_ff : '0;
   assign older_dropped_count = first_ff ? old_count_ff : '0;
   assign own_ack_mask = receive_mask_ff;
   assign last_of_run = sts.is_last;
   assign type_limit = type_limit_ff;

endmodule

/* src/selective_ack_window_tracker_core.sv */
// Selective-ack window tracker.
// The req channel carries one received packet header per transaction
// (type, sequence, peer's highest ack, 64-bit peer ack mask). For a valid
// type the rsp channel delivers one transaction per newly covered sent
// sequence inside the 64-sequence window, oldest first, each marked
// acknowledged or dropped; the first carries the count of older drops and
// last_of_run marks the final one. A header with nothing new gives one
// transaction with verdict 0; an invalid type gives none.
// After the header is taken the block passes through the type check and
// then the run setup before the first result is valid. Results then leave
// one per cycle while the receiver is ready; an invalid header returns the
// block to idle after the type check. The result step loop of the
// controller paces the run; req ready is high only while the block is idle.
// When the receiver stalls the current result holds and the run pauses.
// Synchronous reset clears the ack history, receive mask and sequence
// state, and sets type_limit (APB register at byte address 0) to 16.
module selective_ack_window_tracker_core (
   input  logic                                 clock,
   input  logic                                 reset,
   sawt_req_if.sink                             req_ch,
   sawt_rsp_if.source                           rsp_ch,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [sawt_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [sawt_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [sawt_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   sawt_pkg::cmd_type              cmd;
   sawt_pkg::sts_type              sts;
   logic                           cfg_write;
   logic                           sel_type_limit;
   logic [sawt_pkg::TYPE_W-1:0]    type_limit;

   // register decode
   assign sel_type_limit = (paddr[sawt_pkg::CSR_ADDR_W-1:2] == sawt_pkg::REG_TYPE_LIMIT);
   assign cfg_write = psel && penable && pwrite && sel_type_limit;
   assign pready = 1'b1;
   assign prdata = sel_type_limit ? {{(sawt_pkg::CSR_DATA_W-sawt_pkg::TYPE_W){1'b0}}, type_limit}
                                  : '0;

   sawt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sawt_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .cfg_write           (cfg_write),
      .cfg_type_limit      (pwdata[sawt_pkg::TYPE_W-1:0]),
      .type_limit          (type_limit),
      .packet_type         (req_ch.packet_type),
      .rx_sequence         (req_ch.rx_sequence),
      .peer_highest_ack    (req_ch.peer_highest_ack),
      .peer_ack_mask       (req_ch.peer_ack_mask),
      .report_sequence     (rsp_ch.report_sequence),
      .verdict             (rsp_ch.verdict),
      .older_dropped_first (rsp_ch.older_dropped_first),
      .older_dropped_count (rsp_ch.older_dropped_count),
      .own_ack_mask        (rsp_ch.own_ack_mask),
      .last_of_run         (rsp_ch.last_of_run)
   );

endmodule

/* src/sawt_checker.sv */
module sawt_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [sawt_pkg::SEQ_W-1:0]         report_sequence,
   input  logic [sawt_pkg::VERDICT_W-1:0]     verdict,
   input  logic [sawt_pkg::SEQ_W-1:0]         older_dropped_count,
   input  logic                               last_of_run
);

   // no new header is taken while a run is being delivered
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("req ready while results pending");

   // a stalled result keeps its sequence
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(report_sequence)))
      else $error("stalled result changed");

   // within a run sequences step by one and older drops come only first
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !last_of_run) |=>
         (rsp_valid && report_sequence == $past(report_sequence) + 32'd1
          && older_dropped_count == '0))
      else $error("run sequence broken");

   // a nothing-new result stands alone
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && verdict == sawt_pkg::VERDICT_NONE) |-> last_of_run)
      else $error("nothing-new result not last");

   // a header with a result cannot show it before setup finishes
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("result too early");

endmodule

bind selective_ack_window_tracker_core sawt_checker u_sawt_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .report_sequence     (rsp_ch.report_sequence),
   .verdict             (rsp_ch.verdict),
   .older_dropped_count (rsp_ch.older_dropped_count),
   .last_of_run         (rsp_ch.last_of_run)
);
